[rtl/c3d_pkg.sv]
// Shared constants, types and helpers of the 3D curl stencil.
`default_nettype none
package c3d_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int MAX_DEPTH   = 1024;
   localparam int SAMPLE_BITS = 16;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int ZW = $clog2(MAX_DEPTH);

   localparam int GW_BITS    = 7;
   localparam int GH_BITS    = 7;
   localparam int GD_BITS    = 11;
   localparam int RECIP_BITS = 16;
   localparam int ROT_BITS   = 27;
   localparam int MIN_SIZE   = 3;

   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + RECIP_BITS + 1;
   localparam int FRAC_BITS = 8;
   localparam int DER_BITS  = PROD_BITS - 1 - FRAC_BITS;

   localparam int ADDR_BITS = 1 + YW + XW;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR   = $clog2(FIFO_DEPTH);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_WIDTH  = 3'd0,
      CSR_GRID_HEIGHT = 3'd1,
      CSR_GRID_DEPTH  = 3'd2,
      CSR_INV_TWO_DX  = 3'd3,
      CSR_INV_TWO_DY  = 3'd4,
      CSR_INV_TWO_DZ  = 3'd5
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [DIFF_BITS-1:0]   diff_type;
   typedef logic signed [DER_BITS-1:0]    der_type;
   typedef logic signed [ROT_BITS-1:0]    rot_type;

   typedef struct packed {
      logic [GW_BITS-1:0]    grid_width;
      logic [GH_BITS-1:0]    grid_height;
      logic [GD_BITS-1:0]    grid_depth;
      logic [RECIP_BITS-1:0] inv_two_dx;
      logic [RECIP_BITS-1:0] inv_two_dy;
      logic [RECIP_BITS-1:0] inv_two_dz;
   } cfg_type;

   typedef struct packed {
      diff_type        dfz_dy;
      diff_type        dfy_dz;
      diff_type        dfx_dz;
      diff_type        dfz_dx;
      diff_type        dfy_dx;
      diff_type        dfx_dy;
      logic [XW-1:0]   cx;
      logic [YW-1:0]   cy;
      logic [ZW-1:0]   cz;
      logic            done;
   } job_type;

   function automatic logic [GD_BITS-1:0] clamp_size(input logic [GD_BITS-1:0] v,
                                                     input logic [GD_BITS-1:0] maxv);
      logic [GD_BITS-1:0] r;
      if (v < GD_BITS'(MIN_SIZE)) begin
         r = GD_BITS'(MIN_SIZE);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/c3d_req_if.sv]
// Input channel: one field sample per word.
`default_nettype none
interface c3d_req_if
   import c3d_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type field_x;
   sample_type field_y;
   sample_type field_z;

   modport source(output valid, output field_x, output field_y, output field_z,
                  input ready);
   modport sink(input valid, input field_x, input field_y, input field_z,
                output ready);
endinterface
`default_nettype wire

[rtl/c3d_rsp_if.sv]
// Result channel: one curl word per interior point.
`default_nettype none
interface c3d_rsp_if
   import c3d_pkg::*;
   ();
   logic          valid;
   logic          ready;
   rot_type       rot_x;
   rot_type       rot_y;
   rot_type       rot_z;
   logic [XW-1:0] center_x;
   logic [YW-1:0] center_y;
   logic [ZW-1:0] center_z;
   logic          volume_done;

   modport source(output valid, output rot_x, output rot_y, output rot_z,
                  output center_x, output center_y, output center_z,
                  output volume_done, input ready);
   modport sink(input valid, input rot_x, input rot_y, input rot_z,
                input center_x, input center_y, input center_z,
                input volume_done, output ready);
endinterface
`default_nettype wire

[rtl/c3d_front.sv]
// Front end: position counters, plane memories, interior classification, differences.
`default_nettype none
module c3d_front
   import c3d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic [FIFO_PTR:0] fifo_count,
   c3d_req_if.sink            req_ch,
   output logic               job_valid,
   output job_type            job
);

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int MEM_DEPTH = 2 ** ADDR_BITS;

   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [ZW-1:0] z_ff, z_in;

   logic [GD_BITS-1:0] w, h, d, xe, ye, ze;
   logic accept, interior, done;
   logic [ADDR_BITS-1:0] a_wr, a_yp, a_ym, a_xp, a_xm;

   logic [PW-1:0] mem_a [MEM_DEPTH];  // fx, fz
   logic [PW-1:0] mem_b [MEM_DEPTH];  // fy, fz
   logic [PW-1:0] mem_c [MEM_DEPTH];  // fx, fy

   logic [PW-1:0] rd_yp_ff, rd_ym_ff, rd_xp_ff, rd_xm_ff, rd_zm_ff;
   sample_type    sx_ff, sy_ff;
   logic          s1_v_ff;
   logic [XW-1:0] cx_ff;
   logic [YW-1:0] cy_ff;
   logic [ZW-1:0] cz_ff;
   logic          done_ff;

   always_comb begin
      w  = clamp_size(GD_BITS'(cfg.grid_width), GD_BITS'(MAX_WIDTH));
      h  = clamp_size(GD_BITS'(cfg.grid_height), GD_BITS'(MAX_HEIGHT));
      d  = clamp_size(cfg.grid_depth, GD_BITS'(MAX_DEPTH));
      xe = GD_BITS'(x_ff);
      ye = GD_BITS'(y_ff);
      ze = GD_BITS'(z_ff);
      req_ch.ready = (({1'b0, fifo_count} + (FIFO_PTR+2)'(s1_v_ff)) <
                      (FIFO_PTR+2)'(FIFO_DEPTH));
      accept   = req_ch.valid && req_ch.ready;
      interior = (ze >= GD_BITS'(2)) && (ze < d) && (xe >= GD_BITS'(1)) &&
                 (xe + GD_BITS'(2) <= w) && (ye >= GD_BITS'(1)) &&
                 (ye + GD_BITS'(2) <= h);
      done     = (xe + GD_BITS'(2) == w) && (ye + GD_BITS'(2) == h) &&
                 (ze + GD_BITS'(1) == d);
      a_wr = {z_ff[0], y_ff, x_ff};
      a_yp = {~z_ff[0], y_ff + YW'(1), x_ff};
      a_ym = {~z_ff[0], y_ff - YW'(1), x_ff};
      a_xp = {~z_ff[0], y_ff, x_ff + XW'(1)};
      a_xm = {~z_ff[0], y_ff, x_ff - XW'(1)};
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (accept) begin
         if (xe + GD_BITS'(1) >= w) begin
            x_in = '0;
            if (ye + GD_BITS'(1) >= h) begin
               y_in = '0;
               if (ze + GD_BITS'(1) >= d) begin
                  z_in = '0;
               end else begin
                  z_in = z_ff + ZW'(1);
               end
            end else begin
               y_in = y_ff + YW'(1);
            end
         end else begin
            x_in = x_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         s1_v_ff <= accept && interior;
      end
   end

   // read-first: the z-2 sample leaves as the new one is written
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_yp_ff    <= mem_a[a_yp];
         rd_ym_ff    <= mem_a[a_ym];
         rd_xp_ff    <= mem_b[a_xp];
         rd_xm_ff    <= mem_b[a_xm];
         rd_zm_ff    <= mem_c[a_wr];
         mem_a[a_wr] <= {req_ch.field_x, req_ch.field_z};
         mem_b[a_wr] <= {req_ch.field_y, req_ch.field_z};
         mem_c[a_wr] <= {req_ch.field_x, req_ch.field_y};
         sx_ff       <= req_ch.field_x;
         sy_ff       <= req_ch.field_y;
         cx_ff       <= x_ff;
         cy_ff       <= y_ff;
         cz_ff       <= z_ff - ZW'(1);
         done_ff     <= done;
      end
   end

   function automatic diff_type sub(input logic [SAMPLE_BITS-1:0] a,
                                    input logic [SAMPLE_BITS-1:0] b);
      return diff_type'($signed({a[SAMPLE_BITS-1], a}) - $signed({b[SAMPLE_BITS-1], b}));
   endfunction

   always_comb begin
      job_valid  = s1_v_ff;
      job.dfz_dy = sub(rd_yp_ff[SAMPLE_BITS-1:0], rd_ym_ff[SAMPLE_BITS-1:0]);
      job.dfx_dy = sub(rd_yp_ff[PW-1:SAMPLE_BITS], rd_ym_ff[PW-1:SAMPLE_BITS]);
      job.dfz_dx = sub(rd_xp_ff[SAMPLE_BITS-1:0], rd_xm_ff[SAMPLE_BITS-1:0]);
      job.dfy_dx = sub(rd_xp_ff[PW-1:SAMPLE_BITS], rd_xm_ff[PW-1:SAMPLE_BITS]);
      job.dfx_dz = sub(sx_ff, rd_zm_ff[PW-1:SAMPLE_BITS]);
      job.dfy_dz = sub(sy_ff, rd_zm_ff[SAMPLE_BITS-1:0]);
      job.cx     = cx_ff;
      job.cy     = cy_ff;
      job.cz     = cz_ff;
      job.done   = done_ff;
   end

endmodule
`default_nettype wire

[rtl/c3d_fifo.sv]
// Short job queue between front and back.
`default_nettype none
module c3d_fifo
   import c3d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire job_type       push_job,
   input  wire logic          pop,
   output job_type            head,
   output logic               not_empty,
   output logic [FIFO_PTR:0]  count
);

   job_type             slots_ff [FIFO_DEPTH];
   logic [FIFO_PTR-1:0] wp_ff, rp_ff;
   logic [FIFO_PTR:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (FIFO_PTR+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_PTR+1)'(1);
      end
      head      = slots_ff[rp_ff];
      not_empty = (count_ff != '0);
      count     = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wp_ff <= wp_ff + FIFO_PTR'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + FIFO_PTR'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wp_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

[rtl/c3d_back.sv]
// Back end: scaling multiplies, curl sums and the output register.
`default_nettype none
module c3d_back
   import c3d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    job_avail,
   input  wire job_type job,
   output logic         pop,
   c3d_rsp_if.source    rsp_ch
);

   logic    m_v_ff, o_v_ff;
   logic    o_adv, m_adv;
   der_type zy_ff, yz_ff, xz_ff, zx_ff, yx_ff, xy_ff;
   logic [XW-1:0] mx_ff;
   logic [YW-1:0] my_ff;
   logic [ZW-1:0] mz_ff;
   logic          md_ff;
   rot_type rx_ff, ry_ff, rz_ff;
   logic [XW-1:0] ox_ff;
   logic [YW-1:0] oy_ff;
   logic [ZW-1:0] oz_ff;
   logic          od_ff;

   function automatic der_type scale(input diff_type dv, input logic [RECIP_BITS-1:0] r);
      logic signed [PROD_BITS-1:0] p;
      p = PROD_BITS'(dv) * $signed({1'b0, r});
      return p[PROD_BITS-2:FRAC_BITS];
   endfunction

   always_comb begin
      o_adv = !o_v_ff || rsp_ch.ready;
      m_adv = !m_v_ff || o_adv;
      pop   = job_avail && m_adv;
      rsp_ch.valid       = o_v_ff;
      rsp_ch.rot_x       = rx_ff;
      rsp_ch.rot_y       = ry_ff;
      rsp_ch.rot_z       = rz_ff;
      rsp_ch.center_x    = ox_ff;
      rsp_ch.center_y    = oy_ff;
      rsp_ch.center_z    = oz_ff;
      rsp_ch.volume_done = od_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (m_adv) begin
            m_v_ff <= job_avail;
         end
         if (o_adv) begin
            o_v_ff <= m_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         zy_ff <= scale(job.dfz_dy, cfg.inv_two_dy);
         xy_ff <= scale(job.dfx_dy, cfg.inv_two_dy);
         zx_ff <= scale(job.dfz_dx, cfg.inv_two_dx);
         yx_ff <= scale(job.dfy_dx, cfg.inv_two_dx);
         yz_ff <= scale(job.dfy_dz, cfg.inv_two_dz);
         xz_ff <= scale(job.dfx_dz, cfg.inv_two_dz);
         mx_ff <= job.cx;
         my_ff <= job.cy;
         mz_ff <= job.cz;
         md_ff <= job.done;
      end
      if (o_adv && m_v_ff) begin
         rx_ff <= ROT_BITS'(zy_ff) - ROT_BITS'(yz_ff);
         ry_ff <= ROT_BITS'(xz_ff) - ROT_BITS'(zx_ff);
         rz_ff <= ROT_BITS'(yx_ff) - ROT_BITS'(xy_ff);
         ox_ff <= mx_ff;
         oy_ff <= my_ff;
         oz_ff <= mz_ff;
         od_ff <= md_ff;
      end
   end

endmodule
`default_nettype wire

[rtl/curl_3d_stencil_stream.sv]
// Top level of the streaming 3D curl stencil.
//   channel   dir  handshake     word
//   req_ch    in   valid/ready   field_x, field_y, field_z
//   rsp_ch    out  valid/ready   rot_x/y/z, center_x/y/z, volume_done
//   csr_*     in   csr_we        csr_index, csr_wdata
// One sample per cycle while the output does not stall; a stencil's result
// passes the memory read, queue, multiply and sum registers before leaving.
// Throughput is set by the single write port of the plane memories.
// Synchronous reset clears counters and valids; memories are not cleared.
// Output stalls fill the 4-entry queue, then req_ch.ready drops.
`default_nettype none
module curl_3d_stencil_stream
   import c3d_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   c3d_req_if.sink                        req_ch,
   c3d_rsp_if.source                      rsp_ch
);

   cfg_type            cfg_ff, cfg_in;
   logic               job_valid, pop, not_empty;
   job_type            job, head;
   logic [FIFO_PTR:0]  fifo_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_wdata[GW_BITS-1:0];
            CSR_GRID_HEIGHT: cfg_in.grid_height = csr_wdata[GH_BITS-1:0];
            CSR_GRID_DEPTH:  cfg_in.grid_depth  = csr_wdata[GD_BITS-1:0];
            CSR_INV_TWO_DX:  cfg_in.inv_two_dx  = csr_wdata[RECIP_BITS-1:0];
            CSR_INV_TWO_DY:  cfg_in.inv_two_dy  = csr_wdata[RECIP_BITS-1:0];
            CSR_INV_TWO_DZ:  cfg_in.inv_two_dz  = csr_wdata[RECIP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= GW_BITS'(64);
         cfg_ff.grid_height <= GH_BITS'(64);
         cfg_ff.grid_depth  <= GD_BITS'(64);
         cfg_ff.inv_two_dx  <= RECIP_BITS'(128);
         cfg_ff.inv_two_dy  <= RECIP_BITS'(128);
         cfg_ff.inv_two_dz  <= RECIP_BITS'(128);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   c3d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_count (fifo_count),
      .req_ch     (req_ch),
      .job_valid  (job_valid),
      .job        (job)
   );

   c3d_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_job  (job),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (fifo_count)
   );

   c3d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_avail (not_empty),
      .job       (head),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTHESIS
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= (FIFO_PTR+1)'(FIFO_DEPTH))
      else $error("job queue overflow");

   a_job_from_accept: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> $past(req_ch.valid && req_ch.ready))
      else $error("job without accepted word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
